// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define DCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define DCM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dcm_pkg.sv
// Shared constants, register indexes and types of the delay crossfade mixer.
package dcm_pkg;

  localparam int CHANNELS        = 2;
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int GAIN_BITS = 24;
  localparam int GAIN_FRAC = 23;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'h800000;

  localparam int DELAY_BITS     = 12;
  localparam int WARM_BITS      = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [GAIN_BITS-1:0] MIX_STEP_RESET = 24'd8738;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_FRAMES     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_STEP         = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_PRESENT      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTGOING_PRESENT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_GAIN_START   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_GAIN_START  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP_FRAMES    = 3'd6;

  // Per-frame weights handed from the front to the mixing back end.
  typedef struct packed {
    logic [GAIN_BITS-1:0] g_dry;
    logic [GAIN_BITS-1:0] g_own;
    logic [GAIN_BITS-1:0] g_fade;
    logic                 settled;
  } mix_ctl_t;

endpackage

// File: src/dcm_front.sv
// Front end: frame intake, gain ramps, dry delay store and weight selection.
module dcm_front #(
  parameter int SAMPLE_BITS = dcm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_DELAY   = dcm_pkg::MAX_DELAY_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [dcm_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [dcm_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  input  logic                                        frame_valid,
  output logic                                        frame_stall,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    dry,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    own,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    fade,
  output logic                                        push_valid,
  input  logic                                        push_full,
  output logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    push_dry,
  output logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    push_own,
  output logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0]    push_fade,
  output dcm_pkg::mix_ctl_t                           push_ctl
);

  localparam int VW = dcm_pkg::CHANNELS * SAMPLE_BITS;
  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = AW + 1;
  localparam int GB = dcm_pkg::GAIN_BITS;

  logic [dcm_pkg::DELAY_BITS-1:0] delay_len;
  logic [GB-1:0]                  mix_step;
  logic                           own_present;
  logic                           outgoing_present;

  logic [GB-1:0]                  own_gain, own_next;
  logic [GB-1:0]                  fade_gain, fade_next;
  logic [dcm_pkg::WARM_BITS-1:0]  warm_count, warm_next;
  logic [AW-1:0]                  wp, wp_next, rp, delay_eff;
  logic [CW-1:0]                  fill;

  logic [VW-1:0] mem [MAX_DELAY];
  logic [VW-1:0] rd_q;

  logic              s1_valid, s1_valid_next;
  logic [VW-1:0]     s1_dry, s1_own, s1_fade;
  logic              s1_bypass, s1_hit;
  dcm_pkg::mix_ctl_t s1_ctl, ctl;

  logic          accept;
  logic [GB-1:0] step, own_up, dry_g, cfg_clamped;
  logic [GB:0]   own_sum;
  logic [GB+1:0] gain_sum;
  logic [AW:0]   rp_wrap;
  logic          plain, fade_heard;

  assign frame_stall = s1_valid && push_full;
  assign accept      = frame_valid && !frame_stall;

  assign step        = (mix_step == '0) ? GB'(1) : mix_step;
  assign own_sum     = {1'b0, own_gain} + {1'b0, step};
  assign own_up      = (own_sum > {1'b0, dcm_pkg::GAIN_ONE}) ? dcm_pkg::GAIN_ONE : own_sum[GB-1:0];
  assign cfg_clamped = (cfg_data > dcm_pkg::GAIN_ONE) ? dcm_pkg::GAIN_ONE : cfg_data;

  always_comb begin
    warm_next = warm_count;
    own_next  = own_gain;
    if (warm_count != '0) begin
      warm_next = warm_count - 1'b1;
    end else if (own_present && own_gain < dcm_pkg::GAIN_ONE) begin
      own_next = own_up;
    end
    fade_next = fade_gain;
    if (fade_gain != '0 && (!own_present || warm_next == '0)) begin
      fade_next = (fade_gain > step) ? fade_gain - step : '0;
    end
  end

  // Dry weight is one minus both path weights, floored at zero.
  assign gain_sum   = {2'b00, own_next} + {2'b00, fade_next};
  assign dry_g      = (gain_sum >= {2'b00, dcm_pkg::GAIN_ONE}) ? '0
                    : dcm_pkg::GAIN_ONE - gain_sum[GB-1:0];
  assign plain      = !own_present && fade_gain == '0;
  assign fade_heard = outgoing_present && fade_gain != '0;

  always_comb begin
    ctl.g_dry   = plain ? dcm_pkg::GAIN_ONE : dry_g;
    ctl.g_own   = own_present ? own_next : '0;
    ctl.g_fade  = fade_heard ? fade_next : '0;
    ctl.settled = own_present && own_gain >= dcm_pkg::GAIN_ONE && fade_gain == '0
                  && warm_count == '0;
  end

  // Delay pointers; an over-long delay is held at the last slot.
  assign delay_eff = (32'(delay_len) >= 32'(MAX_DELAY)) ? AW'(MAX_DELAY - 1)
                                                        : AW'(delay_len);
  assign rp_wrap   = {1'b0, wp} + (AW+1)'(MAX_DELAY) - {1'b0, delay_eff};
  assign rp        = (wp >= delay_eff) ? wp - delay_eff : rp_wrap[AW-1:0];
  assign wp_next   = (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + 1'b1;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (s1_valid && !push_full) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len        <= '0;
      mix_step         <= dcm_pkg::MIX_STEP_RESET;
      own_present      <= 1'b0;
      outgoing_present <= 1'b0;
      own_gain         <= '0;
      fade_gain        <= '0;
      warm_count       <= '0;
      wp               <= '0;
      fill             <= '0;
      s1_valid         <= 1'b0;
    end else begin
      // The user must write registers only while no frame is moving; the block does not enforce this.
      if (cfg_we) begin
        case (cfg_index)
          dcm_pkg::REG_DELAY_FRAMES:     delay_len        <= cfg_data[dcm_pkg::DELAY_BITS-1:0];
          dcm_pkg::REG_MIX_STEP:         mix_step         <= cfg_data;
          dcm_pkg::REG_OWN_PRESENT:      own_present      <= cfg_data[0];
          dcm_pkg::REG_OUTGOING_PRESENT: outgoing_present <= cfg_data[0];
          dcm_pkg::REG_OWN_GAIN_START:   own_gain         <= cfg_clamped;
          dcm_pkg::REG_FADE_GAIN_START:  fade_gain        <= cfg_clamped;
          dcm_pkg::REG_WARMUP_FRAMES:    warm_count       <= cfg_data;
          default: begin
          end
        endcase
      end else if (accept) begin
        own_gain   <= own_next;
        fade_gain  <= fade_next;
        warm_count <= warm_next;
      end
      if (accept) begin
        wp <= wp_next;
        if (fill != CW'(MAX_DELAY)) begin
          fill <= fill + 1'b1;
        end
      end
      s1_valid <= s1_valid_next;
    end
  end

  // Delay store: write this frame, read the delayed one at the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp] <= dry;
      rd_q    <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dry    <= dry;
      s1_own    <= own;
      s1_fade   <= fade;
      s1_ctl    <= ctl;
      s1_bypass <= (delay_eff == '0);
      s1_hit    <= ({1'b0, rp} < fill);
    end
  end

  // Slots never written since reset read as silence.
  assign push_valid = s1_valid;
  assign push_dry   = s1_bypass ? s1_dry : (s1_hit ? rd_q : '0);
  assign push_own   = s1_own;
  assign push_fade  = s1_fade;
  assign push_ctl   = s1_ctl;

endmodule

// File: src/dcm_queue.sv
// Short word queue between the front end and the mixing back end.
module dcm_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = dcm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push, do_pop;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/dcm_back.sv
// Back end: weighted products, sum, round and saturate, output register.
module dcm_back #(
  parameter int SAMPLE_BITS = dcm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0] q_dry,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0] q_own,
  input  logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0] q_fade,
  input  dcm_pkg::mix_ctl_t                        q_ctl,
  output logic                                     mix_valid,
  input  logic                                     mix_stall,
  output logic [dcm_pkg::CHANNELS*SAMPLE_BITS-1:0] mix_out,
  output logic                                     mix_settled
);

  localparam int CH = dcm_pkg::CHANNELS;
  localparam int SB = SAMPLE_BITS;
  localparam int GB = dcm_pkg::GAIN_BITS;
  localparam int FR = dcm_pkg::GAIN_FRAC;
  localparam int PW = SB + GB + 1;
  localparam int SW = PW + 2;
  localparam int RW = SW - FR;

  logic signed [PW-1:0] p_dry [CH];
  logic signed [PW-1:0] p_own [CH];
  logic signed [PW-1:0] p_fade [CH];
  logic                 p_valid, p_settled;
  logic                 adv;
  logic [CH*SB-1:0]     mixed;

  assign adv   = !mix_valid || !mix_stall;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      mix_valid <= 1'b0;
    end else if (adv) begin
      p_valid   <= q_pop;
      mix_valid <= p_valid;
    end
  end

  // One 24-bit gain times one sample per product, registered.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CH; c++) begin
        p_dry[c]  <= $signed(q_dry[c*SB +: SB]) * $signed({1'b0, q_ctl.g_dry});
        p_own[c]  <= $signed(q_own[c*SB +: SB]) * $signed({1'b0, q_ctl.g_own});
        p_fade[c] <= $signed(q_fade[c*SB +: SB]) * $signed({1'b0, q_ctl.g_fade});
      end
      p_settled <= q_ctl.settled;
    end
  end

  // Round half up at the gain point, then clamp to the sample range.
  always_comb begin
    logic [SW-1:0] acc;
    logic [RW-1:0] r;
    logic          over, under;
    mixed = '0;
    for (int c = 0; c < CH; c++) begin
      acc = {{2{p_dry[c][PW-1]}}, p_dry[c]} + {{2{p_own[c][PW-1]}}, p_own[c]}
          + {{2{p_fade[c][PW-1]}}, p_fade[c]} + (SW'(1) << (FR - 1));
      r     = acc[SW-1:FR];
      over  = !r[RW-1] && (|r[RW-2:SB-1]);
      under = r[RW-1] && !(&r[RW-2:SB-1]);
      if (over) begin
        mixed[c*SB +: SB] = {1'b0, {(SB-1){1'b1}}};
      end else if (under) begin
        mixed[c*SB +: SB] = {1'b1, {(SB-1){1'b0}}};
      end else begin
        mixed[c*SB +: SB] = r[SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mix_out     <= mixed;
      mix_settled <= p_settled;
    end
  end

endmodule

// File: src/delay_crossfade_mixer.sv
// Delay crossfade mixer top level: front end, word queue, mixing back end.
// A frame passes the front-end stage register, word queue, product register and output register.
// Throughput: one frame per cycle unless stalled; ramp and store port take one frame each cycle.
// Reset: synchronous; clears gains, pointers, fill count, queue and valid flags.
// The delay store is not swept: a fill count makes unwritten slots read as zero.
`include "assert_macros.svh"

module delay_crossfade_mixer #(
  parameter int SAMPLE_BITS = dcm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_DELAY   = dcm_pkg::MAX_DELAY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               frame_valid,
  output logic                               frame_stall,
  input  logic signed [SAMPLE_BITS-1:0]      dry_left,
  input  logic signed [SAMPLE_BITS-1:0]      dry_right,
  input  logic signed [SAMPLE_BITS-1:0]      own_left,
  input  logic signed [SAMPLE_BITS-1:0]      own_right,
  input  logic signed [SAMPLE_BITS-1:0]      fade_left,
  input  logic signed [SAMPLE_BITS-1:0]      fade_right,
  output logic                               mix_valid,
  input  logic                               mix_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               settled
);

  localparam int VW = dcm_pkg::CHANNELS * SAMPLE_BITS;
  localparam int QW = 3 * VW + $bits(dcm_pkg::mix_ctl_t);

  logic              f_push_valid, q_full, q_empty, q_pop;
  logic [VW-1:0]     f_dry, f_own, f_fade;
  logic [VW-1:0]     b_dry, b_own, b_fade, mix_out;
  dcm_pkg::mix_ctl_t f_ctl, b_ctl;
  logic [QW-1:0]     q_in, q_out;

  assign cfg_ready = 1'b1;

  dcm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_DELAY   (MAX_DELAY)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .dry         ({dry_right, dry_left}),
    .own         ({own_right, own_left}),
    .fade        ({fade_right, fade_left}),
    .push_valid  (f_push_valid),
    .push_full   (q_full),
    .push_dry    (f_dry),
    .push_own    (f_own),
    .push_fade   (f_fade),
    .push_ctl    (f_ctl)
  );

  assign q_in = {f_dry, f_own, f_fade, f_ctl};

  dcm_queue #(
    .WIDTH (QW),
    .DEPTH (dcm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push_valid),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign {b_dry, b_own, b_fade, b_ctl} = q_out;

  dcm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_dry       (b_dry),
    .q_own       (b_own),
    .q_fade      (b_fade),
    .q_ctl       (b_ctl),
    .mix_valid   (mix_valid),
    .mix_stall   (mix_stall),
    .mix_out     (mix_out),
    .mix_settled (settled)
  );

  assign out_left  = mix_out[SAMPLE_BITS-1:0];
  assign out_right = mix_out[2*SAMPLE_BITS-1:SAMPLE_BITS];

  `DCM_ASSERT(a_front_word_held, (f_push_valid && q_full) |=> f_push_valid, "front word dropped while queue full")
  `DCM_ASSERT(a_pop_not_empty, q_pop |-> !q_empty, "pop from empty queue")
  `DCM_ASSERT(a_stall_only_when_full, frame_stall |-> (f_push_valid && q_full), "intake stalled with room")
  `DCM_ASSERT_RST(a_reset_clears, rst |=> (!mix_valid && !f_push_valid && q_empty), "reset left words in flight")

endmodule
